FILE: rtl/core/spi_fram_device_model_unit_defines.svh
// Assertion macros shared by the FRAM device model RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SPI_FRAM_DEVICE_MODEL_UNIT_DEFINES_SVH
`define SPI_FRAM_DEVICE_MODEL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SFDM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfdm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SFDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfdm assertion failed");

`endif

FILE: rtl/core/sfdm_pkg.sv
// Package for the FRAM device model: command codes, frame phases, shared types.
// No dependencies.
package sfdm_pkg;

    // Default memory address width (8 KiB array)
    localparam int MEM_ADDR_BITS_DEF = 13;

    // Bus widths fixed by the interface
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 16;
    localparam int ID_W   = 32;

    // Device ID after reset
    localparam logic [ID_W-1:0] DEVICE_ID_RST = 32'h047F_0101;

    // SPI command opcodes
    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_WREN  = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_RDID  = 8'h9f;

    // Input beat kinds
    localparam logic OP_XFER     = 1'b0;
    localparam logic OP_DESELECT = 1'b1;

    // Frame phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_DATA,
        PH_ID,
        PH_IGNORE
    } t_phase;

    // Memory access request from frame control to the array
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_req;

endpackage

FILE: rtl/core/spi_fram_device_model_unit.sv
// Top level of the serial FRAM device model: handshake, result pipeline, array.
// Depends on sfdm_pkg, sfdm_frame_ctrl, sfdm_ram and the defines header.
//
//  channel   dir  handshake                   payload
//  in        in   i_in_valid / o_in_ready     i_opcode, i_mosi_byte
//  out       out  o_out_valid / i_out_ready   o_miso_byte
//  cfg       in   i_cfg_wr_en                 i_cfg_wr_data (device ID)
//
// One beat per cycle while out does not stall; a result passes the pending stage
// (decode stage issues the array access, registered array read), then the output register.
// Reset is synchronous, active low; it clears frame state, not the array.
// A stall on out backs up through the pending stage to o_in_ready.
`include "spi_fram_device_model_unit_defines.svh"

module spi_fram_device_model_unit #(
    parameter int MEM_ADDR_BITS = sfdm_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [sfdm_pkg::BYTE_W-1:0]   i_mosi_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfdm_pkg::BYTE_W-1:0]   o_miso_byte,
    input  logic                          i_cfg_wr_en,
    input  logic [sfdm_pkg::ID_W-1:0]     i_cfg_wr_data
);

    localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;

    logic                          accept;
    logic                          p_move;
    sfdm_pkg::t_mem_req            mem;
    logic [MEM_ADDR_BITS-1:0]      mem_addr;
    logic [sfdm_pkg::BYTE_W-1:0]   ctrl_miso;
    logic [sfdm_pkg::BYTE_W-1:0]   ram_rdata;

    logic                          r_p_valid;
    logic                          r_p_from_mem;
    logic [sfdm_pkg::BYTE_W-1:0]   r_p_byte;
    logic                          r_o_valid;
    logic [sfdm_pkg::BYTE_W-1:0]   r_o_byte;

    // Handshake: pending stage drains into the output register
    assign p_move     = r_p_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_p_valid || p_move;
    assign accept     = i_in_valid && o_in_ready;

    sfdm_frame_ctrl #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_opcode      (i_opcode),
        .i_mosi_byte   (i_mosi_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_mem         (mem),
        .o_mem_addr    (mem_addr),
        .o_miso_byte   (ctrl_miso)
    );

    sfdm_ram #(
        .WIDTH (sfdm_pkg::BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_re    (mem.re),
        .i_addr  (mem_addr),
        .i_wdata (i_mosi_byte),
        .o_rdata (ram_rdata)
    );

    // Pending stage: holds the beat while the array read data is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_from_mem <= mem.re;
            r_p_byte     <= ctrl_miso;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_byte <= r_p_from_mem ? ram_rdata : r_p_byte;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_miso_byte = r_o_byte;

    // Every accepted beat lands in the pending stage
    `SFDM_ASSERT_NEXT(a_accept_pending, i_clk, i_rst_n, accept, r_p_valid)
    // Pending beat with a free output slot always moves on
    `SFDM_ASSERT_NEXT(a_pending_drains, i_clk, i_rst_n, r_p_valid && !r_o_valid, r_o_valid)
    // A read beat is tagged to take the array data
    `SFDM_ASSERT_NEXT(a_read_tagged, i_clk, i_rst_n, accept && mem.re, r_p_from_mem)

endmodule

FILE: rtl/core/sfdm_ram.sv
// Generic single-port RAM with registered read, no reset on contents.
// No dependencies.
module sfdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/sfdm_frame_ctrl.sv
// Frame control for the FRAM device model: command decode, address, WEL, ID.
// Depends on sfdm_pkg and spi_fram_device_model_unit_defines.svh.
`include "spi_fram_device_model_unit_defines.svh"

module sfdm_frame_ctrl #(
    parameter int MEM_ADDR_BITS = sfdm_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_opcode,
    input  logic [sfdm_pkg::BYTE_W-1:0]      i_mosi_byte,
    input  logic                             i_cfg_wr_en,
    input  logic [sfdm_pkg::ID_W-1:0]        i_cfg_wr_data,
    output sfdm_pkg::t_mem_req               o_mem,
    output logic [MEM_ADDR_BITS-1:0]         o_mem_addr,
    output logic [sfdm_pkg::BYTE_W-1:0]      o_miso_byte
);

    sfdm_pkg::t_phase                r_phase, n_phase;
    logic [sfdm_pkg::BYTE_W-1:0]     r_cmd, n_cmd;
    logic [sfdm_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic                            r_wel, n_wel;
    logic [2:0]                      r_id_idx, n_id_idx;
    logic [sfdm_pkg::ID_W-1:0]       r_dev_id;
    logic [sfdm_pkg::BYTE_W-1:0]     id_byte;
    sfdm_pkg::t_mem_req              mem;
    logic [sfdm_pkg::BYTE_W-1:0]     miso;

    // ID byte for the current index, manufacturer byte first
    always_comb begin
        unique case (r_id_idx[1:0])
            2'd0:    id_byte = r_dev_id[31:24];
            2'd1:    id_byte = r_dev_id[23:16];
            2'd2:    id_byte = r_dev_id[15:8];
            default: id_byte = r_dev_id[7:0];
        endcase
    end

    // Next frame phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_opcode == sfdm_pkg::OP_DESELECT) begin
                n_phase = sfdm_pkg::PH_IDLE;
            end else begin
                unique case (r_phase)
                    sfdm_pkg::PH_IDLE: begin
                        priority if (i_mosi_byte == sfdm_pkg::CMD_READ) begin
                            n_phase = sfdm_pkg::PH_ADDR_HI;
                        end else if (i_mosi_byte == sfdm_pkg::CMD_WRITE) begin
                            n_phase = r_wel ? sfdm_pkg::PH_ADDR_HI : sfdm_pkg::PH_IGNORE;
                        end else if (i_mosi_byte == sfdm_pkg::CMD_RDID) begin
                            n_phase = sfdm_pkg::PH_ID;
                        end else begin
                            n_phase = sfdm_pkg::PH_IGNORE;
                        end
                    end
                    sfdm_pkg::PH_ADDR_HI: n_phase = sfdm_pkg::PH_ADDR_LO;
                    sfdm_pkg::PH_ADDR_LO: n_phase = sfdm_pkg::PH_DATA;
                    sfdm_pkg::PH_DATA:    n_phase = sfdm_pkg::PH_DATA;
                    sfdm_pkg::PH_ID:      n_phase = sfdm_pkg::PH_ID;
                    default:              n_phase = sfdm_pkg::PH_IGNORE;
                endcase
            end
        end
    end

    // Per-beat outputs and data-path register updates
    always_comb begin
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_wel    = r_wel;
        n_id_idx = r_id_idx;
        mem      = '0;
        miso     = '0;
        if (i_accept) begin
            if (i_opcode == sfdm_pkg::OP_DESELECT) begin
                // an accepted WRITE frame drops the latch at deselect
                if (r_cmd == sfdm_pkg::CMD_WRITE && r_phase != sfdm_pkg::PH_IDLE &&
                    r_phase != sfdm_pkg::PH_IGNORE) begin
                    n_wel = 1'b0;
                end
            end else begin
                unique case (r_phase)
                    sfdm_pkg::PH_IDLE: begin
                        n_cmd = i_mosi_byte;
                        if (i_mosi_byte == sfdm_pkg::CMD_WREN) begin
                            n_wel = 1'b1;
                        end
                        if (i_mosi_byte == sfdm_pkg::CMD_RDID) begin
                            n_id_idx = '0;
                        end
                    end
                    sfdm_pkg::PH_ADDR_HI: begin
                        n_addr = {i_mosi_byte, r_addr[7:0]};
                    end
                    sfdm_pkg::PH_ADDR_LO: begin
                        n_addr = {r_addr[15:8], i_mosi_byte};
                    end
                    sfdm_pkg::PH_DATA: begin
                        if (r_cmd == sfdm_pkg::CMD_READ) begin
                            mem.re = 1'b1;
                        end else begin
                            mem.we = 1'b1;
                        end
                        n_addr = r_addr + 16'd1;
                    end
                    sfdm_pkg::PH_ID: begin
                        // four ID bytes, zeros after
                        if (!r_id_idx[2]) begin
                            miso     = id_byte;
                            n_id_idx = r_id_idx + 3'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfdm_pkg::PH_IDLE;
            r_cmd    <= '0;
            r_addr   <= '0;
            r_wel    <= 1'b0;
            r_id_idx <= '0;
        end else begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_addr   <= n_addr;
            r_wel    <= n_wel;
            r_id_idx <= n_id_idx;
        end
    end

    // Device ID register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id <= sfdm_pkg::DEVICE_ID_RST;
        end else if (i_cfg_wr_en) begin
            r_dev_id <= i_cfg_wr_data;
        end
    end

    assign o_mem       = mem;
    assign o_mem_addr  = r_addr[MEM_ADDR_BITS-1:0];
    assign o_miso_byte = miso;

    // A memory write only happens inside a frame opened with the latch set
    `SFDM_ASSERT_NOW(a_write_needs_wel, i_clk, i_rst_n, mem.we, r_wel)
    // Deselect always returns to command phase
    `SFDM_ASSERT_NEXT(a_deselect_idle, i_clk, i_rst_n, i_accept && (i_opcode == sfdm_pkg::OP_DESELECT), r_phase == sfdm_pkg::PH_IDLE)
    // Never read and write the array in the same beat
    `SFDM_ASSERT_NOW(a_mem_excl, i_clk, i_rst_n, mem.re, !mem.we)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for spi_fram_device_model_unit: SPI command frames in, MISO bytes out.
// Depends on sfdm_pkg and the RTL top level; the expected MISO stream comes from a local model.
module testbench;
    import sfdm_pkg::*;

    localparam int          MEM_BITS    = MEM_ADDR_BITS_DEF;
    localparam int          MEM_DEPTH   = 1 << MEM_BITS;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          BEATS_PER_PHASE = 217;
    localparam logic [7:0]  CMD_UNKNOWN = 8'h7f;

    // DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_opcode = OP_XFER;
    logic [BYTE_W-1:0]      i_mosi_byte = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [BYTE_W-1:0]      o_miso_byte;
    logic                   i_cfg_wr_en = 1'b0;
    logic [ID_W-1:0]        i_cfg_wr_data = '0;

    // Chip model state
    t_phase                 frm_phase = PH_IDLE;
    logic [7:0]             frm_cmd = '0;
    logic [ADDR_W-1:0]      frm_addr = '0;
    logic                   wel = 1'b0;
    logic [2:0]             id_pos = '0;
    logic [ID_W-1:0]        id_reg = DEVICE_ID_RST;
    logic [7:0]             fram_mem [MEM_DEPTH];
    bit                     fram_written [MEM_DEPTH];
    int                     written_list [$];

    logic [7:0]             miso_q [$];
    int                     n_fail = 0;
    int                     beats_sent = 0;
    int                     cycles = 0;
    int                     in_idle_pct = 30;
    int                     out_idle_pct = 47;

    typedef struct {
        logic       op;
        logic [7:0] mosi;
        bit         typed;
        logic [7:0] exp;
    } t_dir_row;

    // Directed frames; reads of freshly written bytes go through the model
    t_dir_row dir_rows [29] = '{
        // READ ID after reset, then overrun
        '{OP_XFER, CMD_RDID, 1, 8'h00},
        '{OP_XFER, 8'h00, 1, 8'h04},
        '{OP_XFER, 8'hff, 1, 8'h7f},
        '{OP_XFER, 8'h00, 1, 8'h01},
        '{OP_XFER, 8'hff, 1, 8'h01},
        '{OP_XFER, 8'ha5, 1, 8'h00},
        '{OP_DESELECT, 8'h00, 1, 8'h00},
        // WRITE with latch clear is dropped
        '{OP_XFER, CMD_WRITE, 1, 8'h00},
        '{OP_XFER, 8'h12, 1, 8'h00},
        '{OP_XFER, 8'h34, 1, 8'h00},
        '{OP_DESELECT, 8'hff, 1, 8'h00},
        // unknown command
        '{OP_XFER, CMD_UNKNOWN, 1, 8'h00},
        '{OP_XFER, 8'hff, 1, 8'h00},
        '{OP_DESELECT, 8'h00, 1, 8'h00},
        // WREN with a trailing byte
        '{OP_XFER, CMD_WREN, 1, 8'h00},
        '{OP_XFER, 8'hff, 1, 8'h00},
        '{OP_DESELECT, 8'h00, 1, 8'h00},
        // WRITE at 0xFFFF, second byte wraps to 0
        '{OP_XFER, CMD_WRITE, 1, 8'h00},
        '{OP_XFER, 8'hff, 1, 8'h00},
        '{OP_XFER, 8'hff, 1, 8'h00},
        '{OP_XFER, 8'h00, 1, 8'h00},
        '{OP_XFER, 8'hff, 1, 8'h00},
        '{OP_DESELECT, 8'h00, 1, 8'h00},
        // read both back across the wrap
        '{OP_XFER, CMD_READ, 1, 8'h00},
        '{OP_XFER, 8'hff, 1, 8'h00},
        '{OP_XFER, 8'hff, 1, 8'h00},
        '{OP_XFER, 8'h00, 0, 8'h00},
        '{OP_XFER, 8'hff, 0, 8'h00},
        '{OP_DESELECT, 8'h00, 1, 8'h00}
    };

    spi_fram_device_model_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_mosi_byte  (i_mosi_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_miso_byte  (o_miso_byte),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    // Advance the chip model by one beat, return the MISO byte
    function automatic logic [7:0] fram_step(input logic op, input logic [7:0] mosi);
        logic [7:0] miso;
        int         idx;
        miso = 8'h00;
        idx  = int'(frm_addr[MEM_BITS-1:0]);
        if (op == OP_DESELECT) begin
            if (frm_cmd == CMD_WRITE && frm_phase != PH_IDLE && frm_phase != PH_IGNORE)
                wel = 1'b0;
            frm_phase = PH_IDLE;
        end else begin
            case (frm_phase)
                PH_IDLE: begin
                    frm_cmd = mosi;
                    if (mosi == CMD_READ) begin
                        frm_phase = PH_ADDR_HI;
                    end else if (mosi == CMD_WRITE) begin
                        frm_phase = wel ? PH_ADDR_HI : PH_IGNORE;
                    end else if (mosi == CMD_WREN) begin
                        wel = 1'b1;
                        frm_phase = PH_IGNORE;
                    end else if (mosi == CMD_RDID) begin
                        id_pos = '0;
                        frm_phase = PH_ID;
                    end else begin
                        frm_phase = PH_IGNORE;
                    end
                end
                PH_ADDR_HI: begin
                    frm_addr[15:8] = mosi;
                    frm_phase = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    frm_addr[7:0] = mosi;
                    frm_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (frm_cmd == CMD_READ) begin
                        miso = fram_mem[idx];
                    end else begin
                        fram_mem[idx] = mosi;
                        if (!fram_written[idx]) begin
                            fram_written[idx] = 1'b1;
                            written_list.push_back(idx);
                        end
                    end
                    frm_addr = frm_addr + 16'd1;
                end
                PH_ID: begin
                    if (id_pos < 3'd4) begin
                        miso = 8'((id_reg >> (24 - 8 * id_pos)) & 32'hff);
                        id_pos = id_pos + 3'd1;
                    end
                end
                default: frm_phase = PH_IGNORE;
            endcase
        end
        return miso;
    endfunction

    // Drive one beat, hold it until accepted, queue the expected MISO byte
    task automatic send_beat(input logic op, input logic [7:0] mosi,
                             input bit typed, input logic [7:0] exp);
        logic [7:0] pred;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_mosi_byte <= mosi;
        do @(posedge i_clk); while (!o_in_ready);
        pred = fram_step(op, mosi);
        miso_q.push_back(typed ? exp : pred);
        beats_sent++;
    endtask

    task automatic xfer(input logic [7:0] mosi);
        send_beat(OP_XFER, mosi, 0, 8'h00);
    endtask

    task automatic desel();
        send_beat(OP_DESELECT, 8'($urandom_range(0, 255)), 0, 8'h00);
    endtask

    // Stop sending and wait for every queued result plus pipeline slack
    task automatic drain();
        i_in_valid <= 1'b0;
        while (miso_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_device_id(input logic [ID_W-1:0] val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        id_reg = val;
    endtask

    // Random frames: mostly well formed writes, reads of written bytes and ID reads
    task automatic run_traffic(input int n_beats);
        int               start_cnt;
        int               kind;
        int               len;
        int               idx;
        logic [7:0]       cmd;
        logic [ADDR_W-1:0] addr;
        start_cnt = beats_sent;
        while (beats_sent - start_cnt < n_beats) begin
            kind = $urandom_range(0, 99);
            if (kind >= 30 && kind < 65 && written_list.size() == 0)
                kind = 0;
            if (kind < 30) begin
                xfer(CMD_WREN);
                repeat ($urandom_range(0, 2)) xfer(8'($urandom_range(0, 255)));
                desel();
                xfer(CMD_WRITE);
                xfer(8'($urandom_range(0, 255)));
                xfer(8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 8)) xfer(8'($urandom_range(0, 255)));
                desel();
            end else if (kind < 65) begin
                // start on a written byte, stay inside the written run
                idx = written_list[$urandom_range(0, written_list.size() - 1)];
                len = 0;
                while (len < 8 && fram_written[(idx + len) % MEM_DEPTH])
                    len++;
                addr = 16'($urandom_range(0, 65535));
                addr[MEM_BITS-1:0] = idx[MEM_BITS-1:0];
                xfer(CMD_READ);
                xfer(addr[15:8]);
                xfer(addr[7:0]);
                repeat ($urandom_range(0, len)) xfer(8'($urandom_range(0, 255)));
                desel();
            end else if (kind < 80) begin
                xfer(CMD_RDID);
                repeat ($urandom_range(0, 7)) xfer(8'($urandom_range(0, 255)));
                desel();
            end else if (kind < 90) begin
                // random command; a READ never reaches its data bytes
                cmd = 8'($urandom_range(0, 255));
                xfer(cmd);
                len = (cmd == CMD_READ) ? $urandom_range(0, 2) : $urandom_range(0, 4);
                repeat (len) xfer(8'($urandom_range(0, 255)));
                desel();
            end else if (kind < 95) begin
                xfer(CMD_WRITE);
                repeat ($urandom_range(0, 4)) xfer(8'($urandom_range(0, 255)));
                desel();
            end else begin
                desel();
            end
        end
    endtask

    // Receiver side back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (miso_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got 0x%02h", $time, o_miso_byte);
                n_fail++;
            end else if (o_miso_byte !== miso_q[0]) begin
                $display("%0t: miso_byte mismatch, expected 0x%02h, got 0x%02h",
                         $time, miso_q[0], o_miso_byte);
                n_fail++;
                void'(miso_q.pop_front());
            end else begin
                void'(miso_q.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at the reset device ID
        foreach (dir_rows[i])
            send_beat(dir_rows[i].op, dir_rows[i].mosi, dir_rows[i].typed, dir_rows[i].exp);
        drain();

        set_device_id(32'hffff_ffff);
        run_traffic(BEATS_PER_PHASE);
        drain();

        in_idle_pct  = 47;
        out_idle_pct = 30;
        set_device_id(32'h0000_0000);
        run_traffic(BEATS_PER_PHASE);
        drain();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        set_device_id($urandom);
        run_traffic(BEATS_PER_PHASE);
        drain();
        repeat (10) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
